FILE: rtl/online_greedy_deadline_matcher_core_macros.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef ONLINE_GREEDY_DEADLINE_MATCHER_CORE_MACROS_SVH
`define ONLINE_GREEDY_DEADLINE_MATCHER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define OGDM_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// next-cycle implication
`define OGDM_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

FILE: rtl/ogdm_pkg.sv
// shared types, constants and sizes for the online greedy deadline matcher
// no dependencies
`default_nettype none
package ogdm_pkg;
   localparam int NODE_COUNT_DEF = 64;
   localparam int WAIT_DEPTH_DEF = 16;
   localparam int COST_BITS_DEF  = 16;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_TASK   = 2'd1;
   localparam logic [1:0] KIND_WORKER = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  node_id;
      logic [31:0] arrival_time;
      logic [15:0] duration;
      logic [5:0]  other_id;
      logic [15:0] edge_cost;
      logic        edge_valid;
   } req_type;

   typedef struct packed {
      logic        matched;
      logic [5:0]  partner_id;
      logic [15:0] match_cost;
      logic [15:0] worst_cost;
      logic [5:0]  worst_task;
      logic [5:0]  worst_worker;
      logic        list_overflow;
   } rsp_type;

   // waiting list entry: id, arrival time, duration
   typedef struct packed {
      logic [5:0]  id;
      logic [31:0] arr;
      logic [15:0] dur;
   } entry_type;
endpackage
`default_nettype wire

FILE: rtl/ogdm_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
`default_nettype none
module ogdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/ogdm_wait_list.sv
// one waiting list: ordered entries, compaction by index, append, read port
// depends on ogdm_pkg
`default_nettype none
module ogdm_wait_list #(
   parameter int WAIT_DEPTH = ogdm_pkg::WAIT_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [$clog2(WAIT_DEPTH+1)-1:0] rd_idx,
   output ogdm_pkg::entry_type                rd_entry,
   // copy entry at rd_idx to wr_idx
   input  wire logic                          move_en,
   input  wire logic [$clog2(WAIT_DEPTH+1)-1:0] wr_idx,
   input  wire logic                          append_en,
   input  wire ogdm_pkg::entry_type           append_entry,
   input  wire logic                          count_load,
   input  wire logic [$clog2(WAIT_DEPTH+1)-1:0] count_value,
   output logic      [$clog2(WAIT_DEPTH+1)-1:0] count
);
   localparam int IW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int CW = $clog2(WAIT_DEPTH+1);

   ogdm_pkg::entry_type entry_ff [WAIT_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] rd_sel, wr_sel, app_sel;

   assign rd_sel  = IW'(rd_idx);
   assign wr_sel  = IW'(wr_idx);
   assign app_sel = IW'(count_ff);
   assign rd_entry = entry_ff[rd_sel];
   assign count = count_ff;

   always_comb begin
      count_in = count_ff;
      if (count_load) begin
         count_in = count_value;
      end else if (append_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (move_en) begin
         entry_ff[wr_sel] <= entry_ff[rd_sel];
      end else if (append_en) begin
         entry_ff[app_sel] <= append_entry;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/online_greedy_deadline_matcher_core.sv
// online greedy deadline matcher: one item at a time under a sequencer
// cost load: idle, then the output state, where the table ram is written; an arrival runs
// an expiry pass over both lists, a cost scan through the table ram, a decision, a removal shift
// of the partner list on a match, then output; a new item is taken only back in idle
// reset clears list counts, worst pair and control; the cost table holds garbage until loaded
`default_nettype none
module online_greedy_deadline_matcher_core #(
   parameter int NODE_COUNT = ogdm_pkg::NODE_COUNT_DEF,
   parameter int WAIT_DEPTH = ogdm_pkg::WAIT_DEPTH_DEF,
   parameter int COST_BITS  = ogdm_pkg::COST_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ogdm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ogdm_pkg::rsp_type rsp_data
);
   localparam int NW = $clog2(NODE_COUNT);
   localparam int AW = 2*NW;
   localparam int CW = $clog2(WAIT_DEPTH+1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXP   = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DEC   = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   ogdm_pkg::req_type req_ff, req_in;
   logic side_ff, side_in;            // 0 tasks, 1 workers, during expiry
   logic [CW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic pend_ff, pend_in;            // ram read in flight
   logic [CW-1:0] pend_pos_ff, pend_pos_in;
   logic found_ff, found_in;
   logic [COST_BITS-1:0] best_ff, best_in;
   logic [CW-1:0] best_pos_ff, best_pos_in;
   logic [15:0] worst_cost_ff, worst_cost_in;
   logic [5:0] worst_task_ff, worst_task_in, worst_worker_ff, worst_worker_in;
   logic rsp_valid_ff, rsp_valid_in;
   ogdm_pkg::rsp_type rsp_ff, rsp_in;
   // result built while the previous item may still wait on the output
   ogdm_pkg::rsp_type res_ff, res_in;

   // list ports
   ogdm_pkg::entry_type t_rd, w_rd, app_entry;
   logic [CW-1:0] t_cnt, w_cnt, t_rd_idx, w_rd_idx;
   logic t_move, w_move, t_app, w_app, t_ld, w_ld;
   logic [CW-1:0] t_ldv, w_ldv;

   // ram
   logic ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [COST_BITS:0] ram_wd, ram_rd;

   logic is_task;
   ogdm_pkg::entry_type opp_rd;
   logic [CW-1:0] opp_cnt, own_cnt;
   logic [32:0] deadline;
   logic keep;
   ogdm_pkg::entry_type exp_rd;
   logic [CW-1:0] exp_cnt;
   logic [NW-1:0] opp_id_n, own_id_n;

   assign is_task = (req_ff.kind == ogdm_pkg::KIND_TASK);
   assign opp_rd  = is_task ? w_rd : t_rd;
   assign opp_cnt = is_task ? w_cnt : t_cnt;
   assign own_cnt = is_task ? t_cnt : w_cnt;
   assign exp_rd  = side_ff ? w_rd : t_rd;
   assign exp_cnt = side_ff ? w_cnt : t_cnt;
   assign deadline = {1'b0, exp_rd.arr} + 33'(exp_rd.dur);
   assign keep = (deadline >= {1'b0, req_ff.arrival_time});
   assign opp_id_n = NW'(opp_rd.id);
   assign own_id_n = NW'(req_ff.node_id);

   assign app_entry = '{id: req_ff.node_id, arr: req_ff.arrival_time, dur: req_ff.duration};

   always_comb begin
      ram_we = 1'b0;
      ram_wa = {NW'(req_ff.node_id), NW'(req_ff.other_id)};
      ram_wd = {req_ff.edge_valid, COST_BITS'(req_ff.edge_cost)};
      ram_ra = is_task ? {own_id_n, opp_id_n} : {opp_id_n, own_id_n};
      t_rd_idx = rd_ff; w_rd_idx = rd_ff;
      t_move = 1'b0; w_move = 1'b0; t_app = 1'b0; w_app = 1'b0;
      t_ld = 1'b0; w_ld = 1'b0; t_ldv = wr_ff; w_ldv = wr_ff;
      state_in = state_ff; req_in = req_ff; side_in = side_ff;
      rd_in = rd_ff; wr_in = wr_ff; issue_in = issue_ff;
      pend_in = 1'b0; pend_pos_in = issue_ff;
      found_in = found_ff; best_in = best_ff; best_pos_in = best_pos_ff;
      worst_cost_in = worst_cost_ff; worst_task_in = worst_task_ff;
      worst_worker_in = worst_worker_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff; res_in = res_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (is_task) begin
         w_rd_idx = (state_ff == ST_SCAN) ? issue_ff : rd_ff;
      end else begin
         t_rd_idx = (state_ff == ST_SCAN) ? issue_ff : rd_ff;
      end
      if (state_ff == ST_EXP) begin
         t_rd_idx = rd_ff; w_rd_idx = rd_ff;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               side_in = 1'b0; rd_in = '0; wr_in = '0;
               if (req_data.kind == ogdm_pkg::KIND_LOAD) begin
                  state_in = ST_OUT;      // write in the next cycle, from ST_OUT
               end else if (req_data.kind == ogdm_pkg::KIND_NONE) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EXP;
               end
            end
         end
         ST_EXP: begin
            if (rd_ff < exp_cnt) begin
               if (keep) begin
                  if (side_ff) w_move = 1'b1; else t_move = 1'b1;
                  wr_in = wr_ff + CW'(1);
               end
               rd_in = rd_ff + CW'(1);
            end else begin
               if (side_ff) w_ld = 1'b1; else t_ld = 1'b1;
               rd_in = '0; wr_in = '0;
               if (side_ff) begin
                  state_in = ST_SCAN; issue_in = '0; found_in = 1'b0;
                  best_in = '0; best_pos_in = '0;
               end
               side_in = 1'b1;
            end
         end
         ST_SCAN: begin
            // one table read issued per cycle, compared the cycle after
            if (issue_ff < opp_cnt) begin
               pend_in = 1'b1;
               issue_in = issue_ff + CW'(1);
            end
            if (pend_ff && ram_rd[COST_BITS] && (!found_ff || ram_rd[COST_BITS-1:0] < best_ff)) begin
               found_in = 1'b1;
               best_in = ram_rd[COST_BITS-1:0];
               best_pos_in = pend_pos_ff;
            end
            if (!(issue_ff < opp_cnt) && !pend_ff) begin
               state_in = ST_DEC;
               rd_in = best_pos_ff;
            end
         end
         ST_DEC: begin
            // opp list read at best_pos for partner id
            res_in = '0;
            if (found_ff) begin
               res_in.matched = 1'b1;
               res_in.partner_id = opp_rd.id;
               res_in.match_cost = 16'(best_ff);
               if (!(worst_cost_ff > 16'(best_ff))) begin
                  worst_cost_in = 16'(best_ff);
                  worst_task_in = is_task ? req_ff.node_id : opp_rd.id;
                  worst_worker_in = is_task ? opp_rd.id : req_ff.node_id;
               end
               wr_in = best_pos_ff;
               rd_in = best_pos_ff + CW'(1);
               state_in = ST_SHIFT;
            end else begin
               if (own_cnt >= CW'(WAIT_DEPTH)) begin
                  res_in.list_overflow = 1'b1;
               end else begin
                  if (is_task) t_app = 1'b1; else w_app = 1'b1;
               end
               state_in = ST_OUT;
            end
            res_in.worst_cost = worst_cost_in;
            res_in.worst_task = worst_task_in;
            res_in.worst_worker = worst_worker_in;
         end
         ST_SHIFT: begin
            if (rd_ff < opp_cnt) begin
               if (is_task) w_move = 1'b1; else t_move = 1'b1;
               rd_in = rd_ff + CW'(1);
               wr_in = wr_ff + CW'(1);
            end else begin
               if (is_task) begin
                  w_ld = 1'b1; w_ldv = opp_cnt - CW'(1);
               end else begin
                  t_ld = 1'b1; t_ldv = opp_cnt - CW'(1);
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (req_ff.kind == ogdm_pkg::KIND_LOAD) begin
               ram_we = 1'b1;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         worst_cost_ff <= '0;
         worst_task_ff <= '0;
         worst_worker_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         worst_cost_ff <= worst_cost_in;
         worst_task_ff <= worst_task_in;
         worst_worker_ff <= worst_worker_in;
         pend_ff <= pend_in;
      end
      req_ff <= req_in; side_ff <= side_in; rd_ff <= rd_in; wr_ff <= wr_in;
      issue_ff <= issue_in; pend_pos_ff <= pend_pos_in; found_ff <= found_in;
      best_ff <= best_in; best_pos_ff <= best_pos_in;
      rsp_ff <= rsp_in; res_ff <= res_in;
   end

   ogdm_wait_list #(.WAIT_DEPTH(WAIT_DEPTH)) u_tasks (
      .clock(clock), .reset(reset), .rd_idx(t_rd_idx), .rd_entry(t_rd),
      .move_en(t_move), .wr_idx(wr_ff), .append_en(t_app), .append_entry(app_entry),
      .count_load(t_ld), .count_value(t_ldv), .count(t_cnt)
   );

   ogdm_wait_list #(.WAIT_DEPTH(WAIT_DEPTH)) u_workers (
      .clock(clock), .reset(reset), .rd_idx(w_rd_idx), .rd_entry(w_rd),
      .move_en(w_move), .wr_idx(wr_ff), .append_en(w_app), .append_entry(app_entry),
      .count_load(w_ld), .count_value(w_ldv), .count(w_cnt)
   );

   ogdm_ram #(.WIDTH(COST_BITS+1), .DEPTH(NODE_COUNT*NODE_COUNT)) u_cost (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );
endmodule
`default_nettype wire

FILE: rtl/ogdm_checker.sv
// port-level checker for the matcher core, bound to the matcher core module
// depends on ogdm_pkg and the macro header
`default_nettype none
`include "online_greedy_deadline_matcher_core_macros.svh"
module ogdm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire ogdm_pkg::req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire ogdm_pkg::rsp_type rsp_data
);
   `OGDM_ASSERT_IMP(a_match_excl, clock, reset, rsp_valid, !(rsp_data.matched && rsp_data.list_overflow), "matched and overflow together")
   `OGDM_ASSERT_IMP(a_worst_ge, clock, reset, rsp_valid && rsp_data.matched, rsp_data.worst_cost >= rsp_data.match_cost, "worst cost below match cost")
   `OGDM_ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready && req_data.kind != ogdm_pkg::KIND_NONE, !req_ready, "ready right after accepted item")
   `OGDM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped while stalled")
endmodule
bind online_greedy_deadline_matcher_core ogdm_checker u_ogdm_checker (.*);
`default_nettype wire
